// ===== design/lkv_pkg.sv =====
// Shared types and constants for the LRU key/value cache.
`default_nettype none
package lkv_pkg;

    localparam int KEY_W     = 32;
    localparam int DATA_W    = 32;
    // Slot and rank fields are sized for the largest supported store (256 entries).
    localparam int IDX_MAX_W = 8;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    // Request token that walks the cell chain, gathering lookup results.
    typedef struct packed {
        logic                 valid;
        logic                 is_put;
        logic [KEY_W-1:0]     key;
        logic [DATA_W-1:0]    value;
        logic                 found;
        logic [IDX_MAX_W-1:0] hit_slot;
        logic [DATA_W-1:0]    hit_val;
        logic [IDX_MAX_W-1:0] hit_rank;
        logic                 old_any;
        logic [IDX_MAX_W-1:0] old_slot;
        logic [IDX_MAX_W-1:0] old_rank;
        logic                 free_any;
        logic [IDX_MAX_W-1:0] free_slot;
    } scan_t;

    // Update broadcast to every cell once a scan completes.
    typedef struct packed {
        logic                 write;
        logic                 promote;
        logic                 age_all;
        logic [IDX_MAX_W-1:0] slot;
        logic [IDX_MAX_W-1:0] limit;
        logic [KEY_W-1:0]     key;
        logic [DATA_W-1:0]    value;
    } upd_t;

endpackage
`default_nettype wire

// ===== design/lkv_cell.sv =====
// One storage cell of the cache chain: holds an entry and forwards the scan token.
`default_nettype none
module lkv_cell #(
    parameter int ENTRIES = 16,
    parameter int IDX     = 0
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire lkv_pkg::scan_t scan_in,
    output lkv_pkg::scan_t      scan_out,
    input  wire lkv_pkg::upd_t  upd
);
    import lkv_pkg::*;

    localparam int RW = $clog2(ENTRIES);
    localparam logic [IDX_MAX_W-1:0] MY_SLOT = IDX_MAX_W'(IDX);

    logic [KEY_W-1:0]     key_reg;
    logic [DATA_W-1:0]    val_reg;
    logic                 valid_reg;
    logic [RW-1:0]        rank_reg;
    logic [IDX_MAX_W-1:0] rank_ext;
    scan_t                scan_next;
    scan_t                scan_reg;
    logic                 scan_vld_reg;
    logic                 sel;

    assign rank_ext = IDX_MAX_W'(rank_reg);
    assign sel      = (upd.slot == MY_SLOT);

    always_comb
    begin
        scan_next = scan_in;
        if (valid_reg && !scan_in.found && (key_reg == scan_in.key))
        begin
            scan_next.found    = 1'b1;
            scan_next.hit_slot = MY_SLOT;
            scan_next.hit_val  = val_reg;
            scan_next.hit_rank = rank_ext;
        end
        // Ties go to the later slot, so the oldest search keeps the last maximum.
        if (valid_reg && (!scan_in.old_any || (rank_ext >= scan_in.old_rank)))
        begin
            scan_next.old_any  = 1'b1;
            scan_next.old_slot = MY_SLOT;
            scan_next.old_rank = rank_ext;
        end
        if (!valid_reg && !scan_in.free_any)
        begin
            scan_next.free_any  = 1'b1;
            scan_next.free_slot = MY_SLOT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_vld_reg <= 1'b0;
        end
        else
        begin
            scan_vld_reg <= scan_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
    end

    always_comb
    begin
        scan_out       = scan_reg;
        scan_out.valid = scan_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (upd.write && sel)
        begin
            key_reg <= upd.key;
            val_reg <= upd.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            if (upd.write && sel)
            begin
                valid_reg <= 1'b1;
            end
            if (upd.promote)
            begin
                if (sel)
                begin
                    rank_reg <= '0;
                end
                else if (valid_reg && (upd.age_all || (rank_reg < upd.limit[RW-1:0])))
                begin
                    rank_reg <= rank_reg + 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/lru_key_value_cache.sv =====
// Top level of the LRU key/value cache built as a chain of entry cells.
//
// Requests arrive on start with req_type, key and value; a request is taken at a
// clock edge where start is high and busy is low. A get returns hit and the stored
// value (all ones on a miss); a put returns hit and a value_out of zero.
// Each request walks the chain of ENTRIES cells, one cell per cycle, gathering the
// matching slot, the oldest entry and the first free slot. When it leaves the
// last cell, the update is applied to all cells and the result is registered onto
// hit and value_out with done high for exactly one cycle. busy is low again while
// done is high, so the cache takes one request at a time and a new request can be
// taken while done is high.
// The receiver cannot stall: every result must be taken when done is high.
// The capacity register is written through cfg_valid/cfg_data, always ready, and
// should only be written while the cache is idle. Reset empties the cache and sets
// capacity to 16; keys and values of empty slots are never read.
`default_nettype none
module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       req_type,
    input  wire logic signed [lkv_pkg::KEY_W-1:0]  key,
    input  wire logic signed [lkv_pkg::DATA_W-1:0] value,
    output logic                            done,
    output logic                            hit,
    output logic signed [lkv_pkg::DATA_W-1:0]      value_out,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [4:0]                 cfg_data
);
    import lkv_pkg::*;

    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > 5) ? OCC_W : 5;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [4:0]         capacity_reg;
    logic [OCC_W-1:0]   occ_reg;
    logic [OCC_W-1:0]   occ_next;
    logic               done_reg;
    logic               hit_reg;
    logic               hit_next;
    logic [DATA_W-1:0]  vout_reg;
    logic [DATA_W-1:0]  vout_next;
    logic               accept;
    logic               fin;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   eff_cap;
    scan_t              chain [ENTRIES+1];
    scan_t              last;
    upd_t               upd;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign hit       = hit_reg;
    assign value_out = vout_reg;

    always_comb
    begin
        chain[0]          = '0;
        chain[0].valid    = accept;
        chain[0].is_put   = (req_type == REQ_PUT);
        chain[0].key      = key;
        chain[0].value    = value;
    end

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        lkv_cell #(
            .ENTRIES (ENTRIES),
            .IDX     (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .scan_in  (chain[g]),
            .scan_out (chain[g+1]),
            .upd      (upd)
        );
    end

    assign last = chain[ENTRIES];
    assign fin  = last.valid;

    // Zero acts as one, and anything above the store size saturates.
    assign cap_ext = CMP_W'(capacity_reg);
    assign eff_cap = (cap_ext == '0) ? CMP_W'(1) :
                     (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;

    always_comb
    begin
        upd       = '0;
        upd.key   = last.key;
        upd.value = last.value;
        hit_next  = hit_reg;
        vout_next = vout_reg;
        occ_next  = occ_reg;
        if (fin)
        begin
            hit_next = last.found;
            if (!last.is_put)
            begin
                vout_next = last.found ? last.hit_val : '1;
                if (last.found)
                begin
                    upd.promote = 1'b1;
                    upd.slot    = last.hit_slot;
                    upd.limit   = last.hit_rank;
                end
            end
            else
            begin
                vout_next = '0;
                upd.write   = 1'b1;
                upd.promote = 1'b1;
                if (last.found)
                begin
                    upd.slot  = last.hit_slot;
                    upd.limit = last.hit_rank;
                end
                else
                begin
                    upd.age_all = 1'b1;
                    if (CMP_W'(occ_reg) >= eff_cap)
                    begin
                        // Full: the oldest entry gives up its slot.
                        upd.slot = last.old_slot;
                        if (!last.old_any)
                        begin
                            occ_next = occ_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        upd.slot = last.free_slot;
                        occ_next = occ_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (fin)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            capacity_reg <= 5'd16;
            occ_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            done_reg  <= fin;
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg  <= hit_next;
        vout_reg <= vout_next;
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a request is still in flight");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy && !done))
        else $error("accepted request did not hold the cache busy");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(ENTRIES))
        else $error("occupancy exceeds the number of entries");

    a_get_keeps_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (fin && !last.is_put) |=> $stable(occ_reg))
        else $error("a lookup changed the occupancy");

endmodule
`default_nettype wire
